// File: hdl/lsrdf_pkg.sv
// Shared types and constants for the LCD shadow RAM dirty flush block.
// No dependencies.
`default_nettype none

package lsrdf_pkg;

  localparam int KIND_W   = 2;
  localparam int ADDR_W   = 5;
  localparam int NIBBLE_W = 4;
  localparam int CMD_W    = 8;

  typedef enum logic [KIND_W-1:0] {
    OP_WRITE = 2'd0,
    OP_CLEAR = 2'd1,
    OP_FLUSH = 2'd2,
    OP_CMD   = 2'd3
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [ADDR_W-1:0]   addr;
    logic [NIBBLE_W-1:0] nibble;
    logic [NIBBLE_W-1:0] mask;
    logic [CMD_W-1:0]    command;
  } lsrdf_op_t;

endpackage

`default_nettype wire

// File: hdl/lsrdf_if.sv
// Valid/ready channel interfaces for request items and frame items.
// Depends on lsrdf_pkg.
`default_nettype none

interface lsrdf_in_if
  import lsrdf_pkg::*;
  ;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [ADDR_W-1:0]   addr;
  logic [NIBBLE_W-1:0] nibble;
  logic [NIBBLE_W-1:0] mask;
  logic [CMD_W-1:0]    command;

  modport source (output valid, kind, addr, nibble, mask, command, input ready);
  modport sink   (input valid, kind, addr, nibble, mask, command, output ready);
endinterface

interface lsrdf_out_if
  import lsrdf_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic              frame_type;
  logic              frame_begin;
  logic [ADDR_W-1:0] nibble_addr;
  logic [CMD_W-1:0]  payload;
  logic              frame_end;
  logic              last;

  modport source (output valid, frame_type, frame_begin, nibble_addr, payload,
                  frame_end, last, input ready);
  modport sink   (input valid, frame_type, frame_begin, nibble_addr, payload,
                  frame_end, last, output ready);
endinterface

`default_nettype wire

// File: hdl/lsrdf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lsrdf_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/lsrdf_front.sv
// Front end: accepts request items, drops out-of-range and empty-mask writes,
// and queues the rest in a two-entry queue. Depends on lsrdf_pkg, lsrdf_if.
`default_nettype none

module lsrdf_front
  import lsrdf_pkg::*;
#(
  parameter int RAM_NIBBLES = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lsrdf_in_if.sink   in_ch,
  output logic       q_valid,
  output lsrdf_op_t  q_op,
  input  wire logic  q_pop
);

  lsrdf_op_t  ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  lsrdf_op_t  item;
  logic       accept;
  logic       drop;
  logic       push;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    item.op      = op_t'(in_ch.kind);
    item.addr    = in_ch.addr;
    item.nibble  = in_ch.nibble;
    item.mask    = in_ch.mask;
    item.command = in_ch.command;
  end

  // out-of-range writes and empty masks leave the store untouched
  assign drop = (item.op == OP_WRITE) &&
                (({1'b0, in_ch.addr} >= (ADDR_W + 1)'(RAM_NIBBLES)) ||
                 (in_ch.mask == '0));
  assign push = accept && !drop;

  assign q_valid = (cnt_r != 2'd0);
  assign q_op    = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        ent_r[wr_ptr_r] <= item;
        wr_ptr_r        <= !wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, q_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/lsrdf_back.sv
// Back end: shadow RAM, dirty marks and the flush sequencer with its output
// register. Depends on lsrdf_pkg, lsrdf_if, lsrdf_ram.
`default_nettype none

module lsrdf_back
  import lsrdf_pkg::*;
#(
  parameter int RAM_NIBBLES = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_valid,
  input  lsrdf_op_t  q_op,
  output logic       q_pop,
  lsrdf_out_if.source out_ch
);

  localparam int AW = (RAM_NIBBLES > 1) ? $clog2(RAM_NIBBLES) : 1;
  localparam int CW = $clog2(RAM_NIBBLES + 1);
  localparam logic [RAM_NIBBLES-1:0] ALL_MARKS = '1;

  typedef enum logic [1:0] {ST_IDLE, ST_WR_MOD, ST_FL_SCAN, ST_FL_OUT} state_t;

  state_t                  state_r;
  logic [RAM_NIBBLES-1:0]  dirty_r;
  logic [RAM_NIBBLES-1:0]  vld_r;
  logic [RAM_NIBBLES-1:0]  snap_r;
  logic [RAM_NIBBLES-1:0]  snap_clr;
  logic [RAM_NIBBLES-1:0]  snap_up;
  logic [CW-1:0]           dcnt_r;
  logic [AW-1:0]           ptr_r;
  logic [AW-1:0]           head_idx;
  logic [AW-1:0]           ram_raddr;
  logic [NIBBLE_W-1:0]     wnib_r;
  logic [NIBBLE_W-1:0]     wmask_r;
  logic [NIBBLE_W-1:0]     ram_rdata;
  logic [NIBBLE_W-1:0]     old_val;
  logic [NIBBLE_W-1:0]     new_val;
  logic                    prev_r;
  logic                    slot_free;
  logic                    out_load;
  logic                    ram_re;
  logic                    ram_we;

  logic                    out_valid_r;
  logic                    out_type_r;
  logic                    out_begin_r;
  logic [ADDR_W-1:0]       out_addr_r;
  logic [CMD_W-1:0]        out_payload_r;
  logic                    out_end_r;
  logic                    out_last_r;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.frame_type  = out_type_r;
  assign out_ch.frame_begin = out_begin_r;
  assign out_ch.nibble_addr = out_addr_r;
  assign out_ch.payload     = out_payload_r;
  assign out_ch.frame_end   = out_end_r;
  assign out_ch.last        = out_last_r;

  lsrdf_ram #(
    .WIDTH (NIBBLE_W),
    .DEPTH (RAM_NIBBLES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr_r),
    .wdata (new_val),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    head_idx  = q_op.addr[AW-1:0];
    slot_free = !out_valid_r || out_ch.ready;
    out_load  = ((state_r == ST_IDLE) && q_valid && (q_op.op == OP_CMD) && slot_free) ||
                ((state_r == ST_FL_OUT) && slot_free);
    ram_raddr = (state_r == ST_IDLE) ? head_idx : ptr_r;
    ram_re    = ((state_r == ST_IDLE) && q_valid && (q_op.op == OP_WRITE)) ||
                ((state_r == ST_FL_SCAN) && (snap_r != '0) && snap_r[ptr_r]);
    // unwritten entries read as zero
    old_val   = vld_r[ptr_r] ? ram_rdata : '0;
    new_val   = (old_val & ~wmask_r) | (wnib_r & wmask_r);
    ram_we    = (state_r == ST_WR_MOD) && (new_val != old_val);
    q_pop     = (state_r == ST_IDLE) && q_valid &&
                ((q_op.op != OP_CMD) || slot_free);
    snap_up   = snap_r >> 1;
    snap_clr  = snap_r;
    snap_clr[ptr_r] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      dirty_r     <= ALL_MARKS;
      vld_r       <= '0;
      dcnt_r      <= CW'(RAM_NIBBLES);
      snap_r      <= '0;
      ptr_r       <= '0;
      prev_r      <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            case (q_op.op)
              OP_WRITE: begin
                ptr_r   <= head_idx;
                wnib_r  <= q_op.nibble;
                wmask_r <= q_op.mask;
                state_r <= ST_WR_MOD;
              end
              OP_CLEAR: begin
                vld_r   <= '0;
                dirty_r <= ALL_MARKS;
                dcnt_r  <= CW'(RAM_NIBBLES);
              end
              OP_FLUSH: begin
                if (dcnt_r != '0) begin
                  // more than half dirty: one burst over the whole RAM
                  snap_r  <= (dcnt_r > CW'(RAM_NIBBLES / 2)) ? ALL_MARKS : dirty_r;
                  dirty_r <= '0;
                  dcnt_r  <= '0;
                  ptr_r   <= '0;
                  prev_r  <= 1'b0;
                  state_r <= ST_FL_SCAN;
                end
              end
              OP_CMD: begin
                if (slot_free) begin
                  out_valid_r   <= 1'b1;
                  out_type_r    <= 1'b1;
                  out_begin_r   <= 1'b1;
                  out_addr_r    <= '0;
                  out_payload_r <= q_op.command;
                  out_end_r     <= 1'b1;
                  out_last_r    <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        ST_WR_MOD: begin
          if (ram_we) begin
            vld_r[ptr_r] <= 1'b1;
            if (!dirty_r[ptr_r]) begin
              dirty_r[ptr_r] <= 1'b1;
              dcnt_r         <= dcnt_r + CW'(1);
            end
          end
          state_r <= ST_IDLE;
        end
        ST_FL_SCAN: begin
          if (snap_r == '0) begin
            state_r <= ST_IDLE;
          end else if (snap_r[ptr_r]) begin
            state_r <= ST_FL_OUT;
          end else begin
            prev_r <= 1'b0;
            ptr_r  <= ptr_r + AW'(1);
          end
        end
        ST_FL_OUT: begin
          if (slot_free) begin
            out_valid_r   <= 1'b1;
            out_type_r    <= 1'b0;
            out_begin_r   <= !prev_r;
            out_addr_r    <= ADDR_W'(ptr_r);
            out_payload_r <= {{(CMD_W - NIBBLE_W){1'b0}}, old_val};
            out_end_r     <= !snap_up[ptr_r];
            out_last_r    <= (snap_clr == '0);
            snap_r        <= snap_clr;
            prev_r        <= 1'b1;
            ptr_r         <= ptr_r + AW'(1);
            state_r       <= ST_FL_SCAN;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/lcd_shadow_ram_dirty_flush.sv
// Top level: shadow nibble RAM with dirty marks and burst flush.
// Depends on lsrdf_pkg, lsrdf_if, lsrdf_front, lsrdf_back.
//
//   channel  dir  contents
//   in_ch    in   kind, addr, nibble, mask, command
//   out_ch   out  frame_type, frame_begin, nibble_addr, payload, frame_end, last
//
// Back end steps per item: a write reads the RAM, then writes back in ST_WR_MOD;
// clear-all, command and empty flush are handled in ST_IDLE; a flush with dirty
// nibbles scans addresses up to and including the last one sent, one address per
// cycle in ST_FL_SCAN, and sends each nibble from ST_FL_OUT unless the output stalls.
// Reset sets every dirty mark and clears queue and entry valid bits; no clearing pass.
// A stalled output holds flush and command work; the queue takes items until both entries are full.
`default_nettype none

module lcd_shadow_ram_dirty_flush
  import lsrdf_pkg::*;
#(
  parameter int RAM_NIBBLES = 32
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lsrdf_in_if.sink    in_ch,
  lsrdf_out_if.source out_ch
);

  logic      q_valid;
  lsrdf_op_t q_op;
  logic      q_pop;

  lsrdf_front #(
    .RAM_NIBBLES (RAM_NIBBLES)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_op    (q_op),
    .q_pop   (q_pop)
  );

  lsrdf_back #(
    .RAM_NIBBLES (RAM_NIBBLES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_op    (q_op),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

// File: test/frame_check_pkg.sv
// Scoreboard for the shadow RAM flush block: predicts the frame items of each request.
// Depends on lsrdf_pkg.
`default_nettype none

package frame_check_pkg;
  import lsrdf_pkg::*;

  localparam int NIBBLES = 32;

  typedef struct packed {
    logic              frame_type;
    logic              frame_begin;
    logic [ADDR_W-1:0] nibble_addr;
    logic [CMD_W-1:0]  payload;
    logic              frame_end;
    logic              last;
  } frame_t;

  class frame_scoreboard;
    logic [NIBBLE_W-1:0] shadow [NIBBLES];
    logic [NIBBLES-1:0]  dirty;
    frame_t              pending [$];
    int errors;
    int checked;
    int requests;
    int commands;
    int full_flushes;
    int run_flushes;

    function new();
      foreach (shadow[i]) shadow[i] = '0;
      dirty        = '1;
      errors       = 0;
      checked      = 0;
      requests     = 0;
      commands     = 0;
      full_flushes = 0;
      run_flushes  = 0;
    endfunction

    function void push_run(int lo, int hi, bit closing);
      frame_t f;
      for (int a = lo; a <= hi; a++) begin
        f.frame_type  = 1'b0;
        f.frame_begin = (a == lo);
        f.nibble_addr = a[ADDR_W-1:0];
        f.payload     = {4'b0, shadow[a]};
        f.frame_end   = (a == hi);
        f.last        = closing && (a == hi);
        pending.push_back(f);
      end
    endfunction

    function void flush_dirty();
      int a;
      int b;
      if (dirty == '0) return;
      if ($countones(dirty) > NIBBLES / 2) begin
        full_flushes++;
        push_run(0, NIBBLES - 1, 1'b1);
      end else begin
        run_flushes++;
        a = 0;
        while (a < NIBBLES) begin
          if (dirty[a]) begin
            b = a;
            while (b + 1 < NIBBLES && dirty[b+1]) b++;
            push_run(a, b, (b + 1 >= NIBBLES) || ((dirty >> (b + 1)) == '0));
            a = b + 1;
          end else begin
            a++;
          end
        end
      end
      dirty = '0;
    endfunction

    function void note_request(lsrdf_op_t r);
      logic [NIBBLE_W-1:0] old_val;
      logic [NIBBLE_W-1:0] new_val;
      frame_t f;
      requests++;
      case (r.op)
        OP_WRITE: begin
          if (r.addr < NIBBLES) begin
            old_val = shadow[r.addr];
            new_val = (old_val & ~r.mask) | (r.nibble & r.mask);
            if (new_val != old_val) begin
              shadow[r.addr] = new_val;
              dirty[r.addr]  = 1'b1;
            end
          end
        end
        OP_CLEAR: begin
          foreach (shadow[i]) shadow[i] = '0;
          dirty = '1;
        end
        OP_FLUSH: begin
          flush_dirty();
        end
        default: begin
          commands++;
          f.frame_type  = 1'b1;
          f.frame_begin = 1'b1;
          f.nibble_addr = '0;
          f.payload     = r.command;
          f.frame_end   = 1'b1;
          f.last        = 1'b1;
          pending.push_back(f);
        end
      endcase
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_frame(frame_t got);
      frame_t want;
      checked++;
      if (pending.size() == 0) begin
        report($sformatf("item %0d: no frame pending, got addr %0d payload %02h",
                         checked, got.nibble_addr, got.payload));
        return;
      end
      want = pending.pop_front();
      if (got.frame_type !== want.frame_type)
        report($sformatf("item %0d: frame_type %0b, want %0b",
                         checked, got.frame_type, want.frame_type));
      if (got.frame_begin !== want.frame_begin)
        report($sformatf("item %0d: frame_begin %0b, want %0b",
                         checked, got.frame_begin, want.frame_begin));
      if (got.nibble_addr !== want.nibble_addr)
        report($sformatf("item %0d: nibble_addr %0d, want %0d",
                         checked, got.nibble_addr, want.nibble_addr));
      if (got.payload !== want.payload)
        report($sformatf("item %0d: payload %02h, want %02h",
                         checked, got.payload, want.payload));
      if (got.frame_end !== want.frame_end)
        report($sformatf("item %0d: frame_end %0b, want %0b",
                         checked, got.frame_end, want.frame_end));
      if (got.last !== want.last)
        report($sformatf("item %0d: last %0b, want %0b", checked, got.last, want.last));
    endtask
  endclass

endpackage

`default_nettype wire

// File: test/tb_top.sv
// Top-level testbench: directed and random requests with bursty input and stalled output.
// Depends on lsrdf_pkg, lsrdf_if, frame_check_pkg and the lcd_shadow_ram_dirty_flush RTL.
`default_nettype none

module tb_top;
  import lsrdf_pkg::*;
  import frame_check_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600_000;

  logic clk;
  logic rst_n;
  int   burst_left    = 8;
  int   hold_requests = 0;
  int   cycles        = 0;

  frame_scoreboard sb;

  lsrdf_in_if  in_ch ();
  lsrdf_out_if out_ch ();

  lcd_shadow_ram_dirty_flush i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_frame('{out_ch.frame_type, out_ch.frame_begin, out_ch.nibble_addr,
                       out_ch.payload, out_ch.frame_end, out_ch.last});
  end

  // receiver: changing stall patterns, plus long hold-offs on request
  initial begin
    int mode      = 0;
    int left      = 0;
    int hold_left = 0;
    int seen      = 0;
    int phase     = 0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_requests != seen) begin
        seen      = hold_requests;
        hold_left = 300;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 100);
      end
      left--;
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= (phase % 3 != 0);
        endcase
      end
    end
  end

  function automatic lsrdf_op_t rand_req(op_t op);
    lsrdf_op_t r;
    r.op      = op;
    r.addr    = ADDR_W'($urandom_range(0, 31));
    r.nibble  = NIBBLE_W'($urandom_range(0, 15));
    r.mask    = NIBBLE_W'($urandom_range(0, 15));
    r.command = CMD_W'($urandom_range(0, 255));
    return r;
  endfunction

  // called at a falling edge; returns at a falling edge
  task automatic send_req(lsrdf_op_t r);
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= r.op;
    in_ch.addr    <= r.addr;
    in_ch.nibble  <= r.nibble;
    in_ch.mask    <= r.mask;
    in_ch.command <= r.command;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(r);
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 20);
    end
  endtask

  task automatic do_op(op_t op);
    send_req(rand_req(op));
  endtask

  task automatic do_write(int a, int n, int m);
    lsrdf_op_t r;
    r        = rand_req(OP_WRITE);
    r.addr   = ADDR_W'(a);
    r.nibble = NIBBLE_W'(n);
    r.mask   = NIBBLE_W'(m);
    send_req(r);
  endtask

  task automatic do_cmd(int c);
    lsrdf_op_t r;
    r         = rand_req(OP_CMD);
    r.command = CMD_W'(c);
    send_req(r);
  endtask

  task automatic drain();
    if (in_ch.valid) in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  initial begin
    int  k;
    int  start;
    int  pick;
    bit  contiguous;
    sb = new();
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.kind    = '0;
    in_ch.addr    = '0;
    in_ch.nibble  = '0;
    in_ch.mask    = '0;
    in_ch.command = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: full burst after reset, empty flush, runs, masks, commands
    do_op(OP_FLUSH);
    do_op(OP_FLUSH);
    do_write(0, 4'hF, 4'hF);
    do_write(31, 4'hA, 4'hF);
    do_write(5, 4'h3, 4'h0);
    do_write(6, 4'h0, 4'hF);
    do_write(6, 4'h9, 4'hF);
    do_write(7, 4'h6, 4'h3);
    do_write(7, 4'h2, 4'hF);
    do_write(8, 4'hC, 4'hC);
    do_cmd(8'h00);
    do_cmd(8'hFF);
    do_op(OP_FLUSH);
    do_write(31, 4'h5, 4'hA);
    do_cmd(8'hA5);
    do_op(OP_CLEAR);
    do_write(3, 4'h0, 4'hF);
    do_op(OP_FLUSH);
    do_write(1, 4'hF, 4'hF);
    do_write(30, 4'hF, 4'hF);
    do_write(31, 4'hF, 4'hF);
    do_op(OP_FLUSH);

    // long output hold while requests keep coming, then wait for all frames
    hold_requests++;
    do_op(OP_CLEAR);
    do_op(OP_FLUSH);
    repeat (6) do_cmd($urandom_range(0, 255));
    do_op(OP_FLUSH);
    drain();

    while (sb.requests < 425) begin
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
        k          = $urandom_range(0, 20);
        start      = $urandom_range(0, 31);
        contiguous = ($urandom_range(0, 2) == 0);
        for (int i = 0; i < k; i++) begin
          if ($urandom_range(0, 9) == 0) do_cmd($urandom_range(0, 255));
          do_write(contiguous ? (start + i) % NIBBLES : $urandom_range(0, 31),
                   $urandom_range(0, 15),
                   ($urandom_range(0, 3) != 0) ? 15 : $urandom_range(0, 15));
        end
        do_op(OP_FLUSH);
      end else if (pick < 14) begin
        do_op(OP_CLEAR);
        if ($urandom_range(0, 1) == 1)
          do_write($urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 15));
        do_op(OP_FLUSH);
      end else if (pick < 16) begin
        repeat ($urandom_range(1, 4)) do_cmd($urandom_range(0, 255));
      end else if (pick < 19) begin
        repeat ($urandom_range(1, 6)) do_op(op_t'($urandom_range(0, 3)));
      end else begin
        drain();
      end
    end

    drain();
    repeat (100) @(negedge clk);

    $display("Covered %0d requests: %0d commands, %0d whole-RAM and %0d run-by-run flushes.",
             sb.requests, sb.commands, sb.full_flushes, sb.run_flushes);
    $display("Checked %0d frame items, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire
